>>> sv/srw_pkg.sv
// ============================================================================
// srw_pkg
// Shared constants, codes and types of the selective-repeat receive window.
// ============================================================================
package srw_pkg;

    localparam int SRW_WINDOW_DEPTH = 32;
    localparam int SRW_MAX_PAYLOAD  = 1456;
    localparam int WIN_CAP          = 32;

    localparam logic [5:0] WINDOW_RESET = 6'd32;

    localparam logic OP_PKT     = 1'b0;
    localparam logic OP_TIMEOUT = 1'b1;

    localparam logic [1:0] PKT_START = 2'd0;
    localparam logic [1:0] PKT_END   = 2'd1;
    localparam logic [1:0] PKT_DATA  = 2'd2;
    localparam logic [1:0] PKT_RSVD  = 2'd3;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] seq;
        logic [15:0] tag;
        logic [10:0] len;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [15:0] tag;
        logic [10:0] len;
    } slot_t;

endpackage

>>> sv/srw_if.sv
// ============================================================================
// srw_if
// Channel interfaces: received headers, results and the window register.
// ============================================================================
interface srw_hdr_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [1:0]  pkt_type;
    logic [31:0] seq_num;
    logic [15:0] payload_tag;
    logic [10:0] payload_len;
    logic        crc_ok;
    logic        full_length;

    modport source (output valid, op, pkt_type, seq_num, payload_tag, payload_len,
                    crc_ok, full_length, input ready);
    modport sink (input valid, op, pkt_type, seq_num, payload_tag, payload_len,
                  crc_ok, full_length, output ready);
endinterface

interface srw_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] seq_out;
    logic [15:0] tag_out;
    logic [10:0] len_out;
    logic        last;

    modport source (output valid, kind, seq_out, tag_out, len_out, last, input ready);
    modport sink (input valid, kind, seq_out, tag_out, len_out, last, output ready);
endinterface

interface srw_cfg_if;
    logic       valid;
    logic       ready;
    logic [5:0] win_count;

    modport source (output valid, win_count, input ready);
    modport sink (input valid, win_count, output ready);
endinterface

>>> sv/selective_repeat_receive_window_unit.sv
// An ack is pushed into the output register from the evaluate state that follows the capture of its header beat.
// Each in-order release reads its slot, then pushes the packet out, one release after another.
// A timeout with held packets scans one slot per cycle from the next expected slot to the first held one.
// A new header is taken only in the idle state, once the acks and releases of the last one are pushed.
// Reset clears held flags, window to 32 and next expected to zero; no clearing pass.
// ============================================================================
// selective_repeat_receive_window_unit
// Selective-repeat receive window: acks headers, holds out-of-order data
// packets in a slot memory and releases them in sequence order.
// ============================================================================
module selective_repeat_receive_window_unit
    import srw_pkg::*;
#(
    parameter int WINDOW_DEPTH = SRW_WINDOW_DEPTH,
    parameter int MAX_PAYLOAD  = SRW_MAX_PAYLOAD
)
(
    input  logic      clk,
    input  logic      rst_n,
    srw_hdr_if.sink   hdr,
    srw_res_if.source result,
    srw_cfg_if.sink   cfg
);

    localparam int SW = $clog2(WINDOW_DEPTH);

    logic          push;
    logic          free;
    result_t       res;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    slot_t         wr_data;
    logic          rd_en;
    logic [SW-1:0] rd_addr;
    slot_t         rd_data;

    srw_ctrl #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MAX_PAYLOAD  (MAX_PAYLOAD),
        .SW           (SW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .hdr     (hdr),
        .cfg     (cfg),
        .free    (free),
        .push    (push),
        .res     (res),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    srw_slot_ram #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (SW)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    srw_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .res    (res),
        .free   (free),
        .result (result)
    );

endmodule

>>> sv/srw_slot_ram.sv
// ============================================================================
// srw_slot_ram
// Slot store for held packets: one write port, one registered read port.
// ============================================================================
module srw_slot_ram
    import srw_pkg::*;
#(
    parameter int DEPTH = SRW_WINDOW_DEPTH,
    parameter int AW    = $clog2(SRW_WINDOW_DEPTH)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  slot_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output slot_t         rd_data
);

    slot_t slot_mem [DEPTH];
    slot_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/srw_out_stage.sv
// ============================================================================
// srw_out_stage
// Output register that holds one result beat until the sink takes it.
// ============================================================================
module srw_out_stage
    import srw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  result_t      res,
    output logic         free,
    srw_res_if.source    result
);

    logic    valid_reg;
    result_t data_reg;

    assign free = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (push)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= res;
        end
    end

    assign result.valid   = valid_reg;
    assign result.kind    = data_reg.kind;
    assign result.seq_out = data_reg.seq;
    assign result.tag_out = data_reg.tag;
    assign result.len_out = data_reg.len;
    assign result.last    = data_reg.last;

endmodule

>>> sv/srw_ctrl.sv
// ============================================================================
// srw_ctrl
// Window sequencer: classifies headers, stores data packets in their slots,
// releases the in-order run and answers timeouts.
// ============================================================================
module srw_ctrl
    import srw_pkg::*;
#(
    parameter int WINDOW_DEPTH = SRW_WINDOW_DEPTH,
    parameter int MAX_PAYLOAD  = SRW_MAX_PAYLOAD,
    parameter int SW           = $clog2(SRW_WINDOW_DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    srw_hdr_if.sink       hdr,
    srw_cfg_if.sink       cfg,
    input  logic          free,
    output logic          push,
    output result_t       res,
    output logic          wr_en,
    output logic [SW-1:0] wr_addr,
    output slot_t         wr_data,
    output logic          rd_en,
    output logic [SW-1:0] rd_addr,
    input  slot_t         rd_data
);

    localparam int CAP = (WIN_CAP < WINDOW_DEPTH) ? WIN_CAP : WINDOW_DEPTH;
    localparam logic [5:0]    CAP_W     = 6'(CAP);
    localparam logic [SW:0]   DEPTH_W   = (SW + 1)'(WINDOW_DEPTH);
    localparam logic [SW-1:0] LAST_SLOT = SW'(WINDOW_DEPTH - 1);
    localparam logic [15:0]   MAX_P     = 16'(MAX_PAYLOAD);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_RREAD = 3'd3;
    localparam logic [2:0] S_REL   = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [5:0]              win_reg;
    logic [31:0]             ne_reg, ne_next;
    logic [SW-1:0]           ne_slot_reg, ne_slot_next;
    logic [WINDOW_DEPTH-1:0] held_reg, held_next;
    logic [5:0]              count_reg, count_next;
    logic [SW-1:0]           scan_slot_reg, scan_slot_next;
    logic [4:0]              scan_off_reg, scan_off_next;

    logic        op_reg;
    logic [1:0]  type_reg;
    logic [31:0] seq_reg;
    logic [15:0] tag_reg;
    logic [10:0] len_reg;
    logic        crc_reg;
    logic        full_reg;

    logic [5:0]    eff_win;
    logic [32:0]   win_hi;
    logic          in_win;
    logic [31:0]   seq_diff;
    logic [SW:0]   slot_sum;
    logic [SW-1:0] tgt_slot;
    logic          drop;
    logic          is_data;
    logic          store;
    logic          rel_first;
    logic [SW-1:0] ne_slot_inc;
    logic          more;
    logic [SW-1:0] scan_slot_inc;
    logic [10:0]   len_sat;
    logic          hdr_ready;

    always_comb
    begin
        if (win_reg == 6'd0)
        begin
            eff_win = 6'd1;
        end
        else if (win_reg > CAP_W)
        begin
            eff_win = CAP_W;
        end
        else
        begin
            eff_win = win_reg;
        end
    end

    assign win_hi   = {1'b0, ne_reg} + {27'd0, eff_win};
    assign in_win   = (seq_reg >= ne_reg) && ({1'b0, seq_reg} < win_hi);
    assign seq_diff = seq_reg - ne_reg;
    assign slot_sum = {1'b0, ne_slot_reg} + {1'b0, seq_diff[SW-1:0]};
    assign tgt_slot = (slot_sum >= DEPTH_W) ? SW'(slot_sum - DEPTH_W) : slot_sum[SW-1:0];

    assign is_data   = (type_reg == PKT_DATA);
    assign drop      = (is_data && !crc_reg) || !full_reg || (type_reg == PKT_RSVD);
    assign store     = is_data && in_win && !held_reg[tgt_slot];
    assign rel_first = is_data && (held_reg[ne_slot_reg] || (store && tgt_slot == ne_slot_reg));

    assign ne_slot_inc = ((ne_slot_reg == LAST_SLOT) || (ne_reg == 32'hFFFF_FFFF))
                         ? '0 : ne_slot_reg + 1'b1;
    assign more        = held_reg[ne_slot_inc] && (ne_slot_inc != ne_slot_reg);
    assign scan_slot_inc = (scan_slot_reg == LAST_SLOT) ? '0 : scan_slot_reg + 1'b1;

    assign len_sat = ({5'd0, len_reg} > MAX_P) ? MAX_P[10:0] : len_reg;

    assign wr_addr = tgt_slot;
    assign wr_data = '{tag: tag_reg, len: len_sat};
    assign rd_addr = ne_slot_reg;

    always_comb
    begin
        state_next     = state_reg;
        ne_next        = ne_reg;
        ne_slot_next   = ne_slot_reg;
        held_next      = held_reg;
        count_next     = count_reg;
        scan_slot_next = scan_slot_reg;
        scan_off_next  = scan_off_reg;
        push           = 1'b0;
        res            = '0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        hdr_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                hdr_ready = 1'b1;
                if (hdr.valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (op_reg == OP_TIMEOUT)
                begin
                    if (count_reg != 6'd0)
                    begin
                        scan_slot_next = ne_slot_reg;
                        scan_off_next  = '0;
                        state_next     = S_SCAN;
                    end
                    else if (free)
                    begin
                        push       = 1'b1;
                        res        = '{kind: KIND_ACK, seq: ne_reg, tag: '0, len: '0,
                                       last: 1'b1};
                        state_next = S_IDLE;
                    end
                end
                else if (drop)
                begin
                    state_next = S_IDLE;
                end
                else if (free)
                begin
                    push = 1'b1;
                    res  = '{kind: KIND_ACK, seq: seq_reg, tag: '0, len: '0,
                             last: !rel_first};
                    if (store)
                    begin
                        wr_en               = 1'b1;
                        held_next[tgt_slot] = 1'b1;
                        count_next          = count_reg + 6'd1;
                    end
                    state_next = rel_first ? S_RREAD : S_IDLE;
                end
            end
            S_SCAN:
            begin
                if (held_reg[scan_slot_reg])
                begin
                    if (free)
                    begin
                        push       = 1'b1;
                        res        = '{kind: KIND_ACK, seq: ne_reg + {27'd0, scan_off_reg},
                                       tag: '0, len: '0, last: 1'b1};
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    scan_slot_next = scan_slot_inc;
                    scan_off_next  = scan_off_reg + 5'd1;
                end
            end
            S_RREAD:
            begin
                rd_en      = 1'b1;
                state_next = S_REL;
            end
            S_REL:
            begin
                if (free)
                begin
                    push                   = 1'b1;
                    res                    = '{kind: KIND_DATA, seq: ne_reg, tag: rd_data.tag,
                                               len: rd_data.len, last: !more};
                    held_next[ne_slot_reg] = 1'b0;
                    count_next             = count_reg - 6'd1;
                    ne_next                = ne_reg + 32'd1;
                    ne_slot_next           = ne_slot_inc;
                    state_next             = more ? S_RREAD : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign hdr.ready = hdr_ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            win_reg       <= WINDOW_RESET;
            ne_reg        <= '0;
            ne_slot_reg   <= '0;
            held_reg      <= '0;
            count_reg     <= '0;
            scan_slot_reg <= '0;
            scan_off_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ne_reg        <= ne_next;
            ne_slot_reg   <= ne_slot_next;
            held_reg      <= held_next;
            count_reg     <= count_next;
            scan_slot_reg <= scan_slot_next;
            scan_off_reg  <= scan_off_next;
            if (cfg.valid)
            begin
                win_reg <= cfg.win_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hdr_ready && hdr.valid)
        begin
            op_reg   <= hdr.op;
            type_reg <= hdr.pkt_type;
            seq_reg  <= hdr.seq_num;
            tag_reg  <= hdr.payload_tag;
            len_reg  <= hdr.payload_len;
            crc_reg  <= hdr.crc_ok;
            full_reg <= hdr.full_length;
        end
    end

    // The held count always matches the number of held slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(held_reg) == int'(count_reg))
        else $error("held count does not match held slots");

    // A beat is only pushed into an output register that can take it.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> free)
        else $error("result pushed into a full output register");

    // A release only reads a slot that is held for the next expected number.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REL) |-> held_reg[ne_slot_reg])
        else $error("release from an empty slot");

    // A stored packet marks its slot as held.
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> held_reg[$past(wr_addr)])
        else $error("stored slot not marked held");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the selective-repeat receive window. A predictor
// tracks the held slots and the next expected number, so it knows every ack
// and in-order release that each accepted header or timeout must cause.
// Directed tests cover the edge cases. Random phases then sweep the window
// register under random idling on both channels and a long output stall.
// ============================================================================
module tb_top
    import srw_pkg::*;
();

    localparam int CLK_PERIOD    = 10;
    localparam int SETTLE_CYCLES = 48;

    typedef struct packed {
        logic        op;
        logic [1:0]  ptype;
        logic [31:0] seq;
        logic [15:0] tag;
        logic [10:0] len;
        logic        crc_ok;
        logic        full;
    } hdr_t;

    logic clk = 1'b0;
    logic rst_n;

    srw_hdr_if hdr_ch ();
    srw_res_if res_ch ();
    srw_cfg_if cfg_ch ();

    selective_repeat_receive_window_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .hdr    (hdr_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    logic        win_held [SRW_WINDOW_DEPTH];
    logic [31:0] win_seq  [SRW_WINDOW_DEPTH];
    logic [15:0] win_tag  [SRW_WINDOW_DEPTH];
    logic [10:0] win_len  [SRW_WINDOW_DEPTH];
    logic [31:0] next_seq;
    int unsigned held_total;
    logic [5:0]  window_reg;

    result_t owed_results [$];
    int      mismatches  = 0;
    int      hold_cycles = 0;
    bit      gaps_on     = 1'b1;

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic int unsigned eff_window();
        int unsigned w;
        w = window_reg;
        if (w == 0)
        begin
            w = 1;
        end
        if (w > WIN_CAP)
        begin
            w = WIN_CAP;
        end
        if (w > SRW_WINDOW_DEPTH)
        begin
            w = SRW_WINDOW_DEPTH;
        end
        return w;
    endfunction

    function automatic void owe(result_t r);
        owed_results.insert(owed_results.size(), r);
    endfunction

    // Works out the acks and releases that one accepted beat must cause.
    function automatic void track_arrival(hdr_t h);
        logic [31:0] lowest;
        logic [32:0] lo;
        logic [32:0] hi;
        bit          found;
        int          s;
        if (h.op == OP_TIMEOUT)
        begin
            lowest = next_seq;
            found  = 1'b0;
            if (held_total != 0)
            begin
                for (int i = 0; i < SRW_WINDOW_DEPTH; i++)
                begin
                    if (win_held[i] && (!found || win_seq[i] < lowest))
                    begin
                        lowest = win_seq[i];
                        found  = 1'b1;
                    end
                end
            end
            owe('{KIND_ACK, lowest, 16'd0, 11'd0, 1'b1});
            return;
        end
        if (h.ptype == PKT_DATA && !h.crc_ok)
        begin
            return;
        end
        if (!h.full || h.ptype == PKT_RSVD)
        begin
            return;
        end
        owe('{KIND_ACK, h.seq, 16'd0, 11'd0, 1'b0});
        if (h.ptype == PKT_DATA)
        begin
            lo = {1'b0, next_seq};
            hi = lo + 33'(eff_window());
            if ({1'b0, h.seq} >= lo && {1'b0, h.seq} < hi)
            begin
                s = int'(h.seq % 32'(SRW_WINDOW_DEPTH));
                if (!win_held[s])
                begin
                    win_held[s] = 1'b1;
                    win_seq[s]  = h.seq;
                    win_tag[s]  = h.tag;
                    win_len[s]  = (h.len > SRW_MAX_PAYLOAD) ? 11'(SRW_MAX_PAYLOAD) : h.len;
                    held_total++;
                end
            end
            for (int i = 0; i < WIN_CAP; i++)
            begin
                s = int'(next_seq % 32'(SRW_WINDOW_DEPTH));
                if (!win_held[s] || win_seq[s] != next_seq)
                begin
                    break;
                end
                owe('{KIND_DATA, win_seq[s], win_tag[s], win_len[s], 1'b0});
                win_held[s] = 1'b0;
                if (held_total != 0)
                begin
                    held_total--;
                end
                next_seq = next_seq + 32'd1;
            end
        end
        owed_results[owed_results.size() - 1].last = 1'b1;
    endfunction

    task automatic send_hdr(hdr_t h);
        int gap;
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 18);
            hdr_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        hdr_ch.valid       = 1'b1;
        hdr_ch.op          = h.op;
        hdr_ch.pkt_type    = h.ptype;
        hdr_ch.seq_num     = h.seq;
        hdr_ch.payload_tag = h.tag;
        hdr_ch.payload_len = h.len;
        hdr_ch.crc_ok      = h.crc_ok;
        hdr_ch.full_length = h.full;
        forever
        begin
            @(posedge clk);
            if (hdr_ch.ready)
            begin
                break;
            end
        end
        track_arrival(h);
    endtask

    task automatic settle();
        @(negedge clk);
        hdr_ch.valid = 1'b0;
        while (owed_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(logic [5:0] value);
        @(negedge clk);
        cfg_ch.valid     = 1'b1;
        cfg_ch.win_count = value;
        forever
        begin
            @(posedge clk);
            if (cfg_ch.ready)
            begin
                break;
            end
        end
        window_reg = value;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Mostly data around the next expected number, so that the window fills
    // and drains; the rest is timeouts, control packets and damaged headers.
    function automatic hdr_t pick_header();
        hdr_t        h;
        int unsigned r;
        int unsigned c;
        h.op     = OP_PKT;
        h.ptype  = PKT_DATA;
        h.seq    = next_seq;
        h.tag    = 16'($urandom);
        h.len    = ($urandom_range(0, 4) == 0) ? 11'($urandom) : 11'($urandom_range(0, 1456));
        h.crc_ok = 1'b1;
        h.full   = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            h = hdr_t'({$urandom, $urandom});
            h.op = OP_TIMEOUT;
        end
        else if (r < 14)
        begin
            h.ptype  = ($urandom_range(0, 1) == 0) ? PKT_START : PKT_END;
            h.seq    = ($urandom_range(0, 1) == 0) ? $urandom : next_seq;
            h.crc_ok = 1'($urandom);
        end
        else if (r < 17)
        begin
            h.ptype = PKT_RSVD;
            h.seq   = $urandom;
            h.full  = 1'($urandom);
        end
        else if (r < 22)
        begin
            h.crc_ok = 1'b0;
            h.full   = 1'($urandom);
            h.seq    = next_seq + 32'($urandom_range(0, 3));
        end
        else if (r < 26)
        begin
            h.ptype = 2'($urandom);
            h.full  = 1'b0;
            h.seq   = next_seq;
        end
        else
        begin
            c = $urandom_range(0, 9);
            if (c < 4)
            begin
                h.seq = next_seq;
            end
            else if (c < 8)
            begin
                h.seq = next_seq + 32'($urandom_range(0, eff_window() - 1));
            end
            else if (c == 8)
            begin
                h.seq = next_seq + 32'(eff_window()) + 32'($urandom_range(0, 3));
            end
            else
            begin
                h.seq = ($urandom_range(0, 1) == 0) ? $urandom
                                                    : next_seq - 32'($urandom_range(1, 8));
            end
        end
        return h;
    endfunction

    task automatic send_random(int count);
        for (int i = 0; i < count; i++)
        begin
            send_hdr(pick_header());
        end
    endtask

    task automatic test_control_headers();
        send_hdr('{OP_TIMEOUT, 2'b11, 32'hFFFF_FFFF, 16'hFFFF, 11'h7FF, 1'b1, 1'b1});
        send_hdr('{OP_PKT, PKT_START, 32'h0000_0000, 16'h0000, 11'd0, 1'b1, 1'b1});
        send_hdr('{OP_PKT, PKT_END, 32'hFFFF_FFFF, 16'hFFFF, 11'h7FF, 1'b1, 1'b1});
        send_hdr('{OP_PKT, PKT_START, 32'h0000_0005, 16'h1234, 11'd10, 1'b1, 1'b0});
        send_hdr('{OP_PKT, PKT_START, 32'h8000_0000, 16'h4321, 11'd10, 1'b0, 1'b1});
        send_hdr('{OP_PKT, PKT_RSVD, 32'h0000_0000, 16'h0000, 11'd0, 1'b1, 1'b1});
        send_hdr('{OP_PKT, PKT_DATA, 32'h0000_0000, 16'hAAAA, 11'd100, 1'b0, 1'b1});
        send_hdr('{OP_PKT, PKT_DATA, 32'h0000_0000, 16'h5555, 11'd100, 1'b1, 1'b0});
        send_hdr('{OP_PKT, PKT_DATA, 32'hFFFF_FFFF, 16'hBEEF, 11'd100, 1'b1, 1'b1});
        settle();
    endtask

    task automatic test_in_order_release();
        logic [31:0] base;
        base = next_seq;
        send_hdr('{OP_PKT, PKT_DATA, base, 16'h0000, 11'd0, 1'b1, 1'b1});
        send_hdr('{OP_PKT, PKT_DATA, base + 32'd2, 16'hFFFF, 11'h7FF, 1'b1, 1'b1});
        send_hdr('{OP_PKT, PKT_DATA, base + 32'd1, 16'h00FF, 11'd1456, 1'b1, 1'b1});
        send_hdr('{OP_PKT, PKT_DATA, base + 32'd3, 16'hFF00, 11'd1457, 1'b1, 1'b1});
        send_hdr('{OP_TIMEOUT, PKT_DATA, 32'h0, 16'h0, 11'd0, 1'b0, 1'b0});
        settle();
    endtask

    task automatic test_full_window_reorder();
        logic [31:0] base;
        base = next_seq;
        for (int off = 31; off >= 1; off--)
        begin
            send_hdr('{OP_PKT, PKT_DATA, base + 32'(off), 16'($urandom),
                       11'($urandom_range(0, 1456)), 1'b1, 1'b1});
        end
        send_hdr('{OP_TIMEOUT, PKT_END, 32'h0, 16'h0, 11'd0, 1'b1, 1'b1});
        send_hdr('{OP_PKT, PKT_DATA, base + 32'd5, 16'h0BAD, 11'd7, 1'b1, 1'b1});
        send_hdr('{OP_PKT, PKT_DATA, base + 32'd32, 16'h0BAD, 11'd7, 1'b1, 1'b1});
        send_hdr('{OP_PKT, PKT_DATA, base, 16'hC0DE, 11'd64, 1'b1, 1'b1});
        settle();
    endtask

    task automatic test_window_sweep();
        logic [5:0] sizes [7];
        sizes = '{6'd0, 6'd1, 6'd63, 6'd2, 6'($urandom), 6'($urandom_range(3, 31)), 6'd32};
        foreach (sizes[i])
        begin
            write_window(sizes[i]);
            send_random(30);
            settle();
        end
    endtask

    task automatic test_output_backpressure();
        gaps_on     = 1'b0;
        hold_cycles = 300;
        send_random(40);
        gaps_on = 1'b1;
        settle();
        send_random(30);
        settle();
    endtask

    task automatic test_steady_stream();
        write_window(6'($urandom_range(4, 32)));
        gaps_on = 1'b0;
        send_random(50);
    endtask

    initial
    begin
        int stall;
        stall        = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                res_ch.ready = 1'b0;
                hold_cycles--;
            end
            else if (stall > 0)
            begin
                res_ch.ready = 1'b0;
                stall--;
            end
            else if (gaps_on && $urandom_range(0, 7) == 0)
            begin
                res_ch.ready = 1'b0;
                stall = $urandom_range(0, 17);
            end
            else
            begin
                res_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        result_t seen;
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen = '{res_ch.kind, res_ch.seq_out, res_ch.tag_out, res_ch.len_out, res_ch.last};
            if (owed_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected beat, expected none, ", $time,
                         "actual kind=%0d seq=%08h tag=%04h len=%0d last=%0d",
                         seen.kind, seen.seq, seen.tag, seen.len, seen.last);
            end
            else
            begin
                want = owed_results.pop_front();
                if (seen !== want)
                begin
                    mismatches++;
                    $display("%0t: expected kind=%0d seq=%08h tag=%04h len=%0d last=%0d, ",
                             $time, want.kind, want.seq, want.tag, want.len, want.last,
                             "actual kind=%0d seq=%08h tag=%04h len=%0d last=%0d",
                             seen.kind, seen.seq, seen.tag, seen.len, seen.last);
                end
            end
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        hdr_ch.valid       = 1'b0;
        hdr_ch.op          = OP_PKT;
        hdr_ch.pkt_type    = PKT_START;
        hdr_ch.seq_num     = '0;
        hdr_ch.payload_tag = '0;
        hdr_ch.payload_len = '0;
        hdr_ch.crc_ok      = 1'b0;
        hdr_ch.full_length = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.win_count   = '0;
        foreach (win_held[i])
        begin
            win_held[i] = 1'b0;
        end
        next_seq   = '0;
        held_total = 0;
        window_reg = WINDOW_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_control_headers();
        test_in_order_release();
        test_full_window_reorder();
        test_window_sweep();
        test_output_backpressure();
        test_steady_stream();
        settle();

        if (mismatches == 0 && owed_results.size() == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
